// ===== rtl/cfr_pkg.sv =====
// Shared types and constants for the CAN frame reassembler.
package cfr_pkg;

  localparam int unsigned CHUNK_BYTES = 8;
  localparam int unsigned LANE_BITS   = 3;
  localparam logic [7:0]  MIN_LENGTH  = 8'd5;
  localparam logic [8:0]  SEQ_LIMIT   = 9'd256;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PROC = 4'b0010,
    ST_READ = 4'b0100,
    ST_CAP  = 4'b1000
  } cfr_state_t;

endpackage

// ===== rtl/cfr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module cfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/can_frame_reassembler.sv =====
// Top level of the CAN frame reassembler: frame matching, byte store and chunk output.
//
// Takes one received CAN frame per transaction and rebuilds a serial-line frame
// in a byte store of STORE_BYTES entries, split over eight byte-wide RAM lanes
// so that a whole frame's payload is written, and a whole 8-byte chunk read, in
// a single RAM access. A frame is captured on acceptance and processed in the
// next cycle (ST_PROC). On completion the stored frame leaves as ceil(length/8)
// chunks, each needing a RAM read (ST_READ) then an output register load (ST_CAP);
// a chunk's read waits while the output register holds an untaken chunk. The
// input is not ready again until the last chunk has been loaded into the output
// register. The store is not cleared at reset; only written bytes are ever sent.
module can_frame_reassembler #(
  parameter int unsigned STORE_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [28:0] frame_id,
  input  logic [3:0]  byte_count,
  input  logic [7:0]  data_0,
  input  logic [7:0]  data_1,
  input  logic [7:0]  data_2,
  input  logic [7:0]  data_3,
  input  logic [7:0]  data_4,
  input  logic [7:0]  data_5,
  input  logic [7:0]  data_6,
  input  logic [7:0]  data_7,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  chunk_bytes,
  output logic [7:0]  out_0,
  output logic [7:0]  out_1,
  output logic [7:0]  out_2,
  output logic [7:0]  out_3,
  output logic [7:0]  out_4,
  output logic [7:0]  out_5,
  output logic [7:0]  out_6,
  output logic [7:0]  out_7,
  output logic        last_chunk
);

  import cfr_pkg::*;

  localparam int unsigned ROWS = (STORE_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
  localparam int unsigned RW   = $clog2(ROWS);
  localparam int unsigned CW   = $clog2(STORE_BYTES + 1);
  localparam int unsigned CMPW = (CW > 8) ? CW : 8;

  cfr_state_t state;

  // captured transaction
  logic [28:0] id_q;
  logic [3:0]  dlc_q;
  logic [7:0]  data_q [CHUNK_BYTES];

  logic [7:0]    expected_length;
  logic [7:0]    station_address;
  logic [8:0]    next_sequence;
  logic [CW-1:0] filled_count;
  logic          pending_flag;

  logic [CW-1:0] remaining;
  logic [RW-1:0] rd_row;

  // processing
  logic [3:0]    len;
  logic          is_start;
  logic [7:0]    st_eff;
  logic [8:0]    seq_eff;
  logic [CW-1:0] fc_eff;
  logic [7:0]    el_eff;
  logic          match;
  logic [CW:0]   fc_sum;
  logic [CW-1:0] fc_next;
  logic [8:0]    seq_next;
  logic          pend_next;
  logic          done;

  logic          rd_en;
  logic [7:0]    rd_data [CHUNK_BYTES];
  logic [3:0]    take;

  assign in_ready = (state == ST_IDLE);
  assign rd_en    = (state == ST_READ) && (!out_valid || out_ready);

  always_comb begin
    len      = (dlc_q > 4'(CHUNK_BYTES)) ? 4'(CHUNK_BYTES) : dlc_q;
    is_start = (id_q == {21'b0, data_q[0]});
    st_eff   = is_start ? data_q[0] : station_address;
    seq_eff  = is_start ? 9'd0 : next_sequence;
    fc_eff   = is_start ? '0 : filled_count;
    el_eff   = is_start ? ((data_q[1] >= MIN_LENGTH) ? data_q[1] : 8'd0) : expected_length;
    match    = (id_q[7:0] == st_eff) && ({1'b0, id_q[15:8]} == seq_eff);
    fc_sum   = (CW+1)'(fc_eff) + (CW+1)'(len);
    if (!match) begin
      fc_next = fc_eff;
    end else if (fc_sum > (CW+1)'(STORE_BYTES)) begin
      fc_next = CW'(STORE_BYTES);
    end else begin
      fc_next = fc_sum[CW-1:0];
    end
    seq_next  = (match && seq_eff != SEQ_LIMIT) ? seq_eff + 9'd1 : seq_eff;
    pend_next = match | pending_flag;
    done      = pend_next && (CMPW'(fc_next) == CMPW'(el_eff));
    take      = (remaining > CW'(CHUNK_BYTES)) ? 4'(CHUNK_BYTES) : remaining[3:0];
  end

  // one RAM lane per byte position; byte address a lives in lane a%8, row a/8
  for (genvar b = 0; b < CHUNK_BYTES; b++) begin : g_lane
    logic [LANE_BITS-1:0] k;
    logic [CW:0]          addr;
    logic                 we;

    always_comb begin
      k    = LANE_BITS'(b) - fc_eff[LANE_BITS-1:0];
      addr = (CW+1)'(fc_eff) + (CW+1)'(k);
      we   = (state == ST_PROC) && match && ({1'b0, k} < len) &&
             (addr < (CW+1)'(STORE_BYTES));
    end

    cfr_ram #(
      .WIDTH(8),
      .DEPTH(ROWS)
    ) u_ram (
      .clk  (clk),
      .we   (we),
      .waddr(addr[RW+LANE_BITS-1:LANE_BITS]),
      .wdata(data_q[k]),
      .re   (rd_en),
      .raddr(rd_row),
      .rdata(rd_data[b])
    );
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      id_q      <= frame_id;
      dlc_q     <= byte_count;
      data_q[0] <= data_0;
      data_q[1] <= data_1;
      data_q[2] <= data_2;
      data_q[3] <= data_3;
      data_q[4] <= data_4;
      data_q[5] <= data_5;
      data_q[6] <= data_6;
      data_q[7] <= data_7;
    end
    if (state == ST_CAP) begin
      chunk_bytes <= take;
      last_chunk  <= (remaining <= CW'(CHUNK_BYTES));
      out_0 <= (4'd0 < take) ? rd_data[0] : 8'd0;
      out_1 <= (4'd1 < take) ? rd_data[1] : 8'd0;
      out_2 <= (4'd2 < take) ? rd_data[2] : 8'd0;
      out_3 <= (4'd3 < take) ? rd_data[3] : 8'd0;
      out_4 <= (4'd4 < take) ? rd_data[4] : 8'd0;
      out_5 <= (4'd5 < take) ? rd_data[5] : 8'd0;
      out_6 <= (4'd6 < take) ? rd_data[6] : 8'd0;
      out_7 <= (4'd7 < take) ? rd_data[7] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      expected_length <= '0;
      station_address <= '0;
      next_sequence   <= '0;
      filled_count    <= '0;
      pending_flag    <= 1'b0;
      remaining       <= '0;
      rd_row          <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_PROC;
          end
        end
        ST_PROC: begin
          expected_length <= el_eff;
          station_address <= st_eff;
          next_sequence   <= seq_next;
          filled_count    <= fc_next;
          pending_flag    <= pend_next & ~done;
          remaining       <= fc_next;
          rd_row          <= '0;
          // an empty completion just clears the flag
          state <= (done && fc_next != '0) ? ST_READ : ST_IDLE;
        end
        ST_READ: begin
          if (rd_en) begin
            state <= ST_CAP;
          end
        end
        ST_CAP: begin
          out_valid <= 1'b1;
          remaining <= remaining - CW'(take);
          rd_row    <= rd_row + RW'(1);
          state     <= (remaining <= CW'(CHUNK_BYTES)) ? ST_IDLE : ST_READ;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    filled_count <= CW'(STORE_BYTES))
    else $error("filled_count beyond store size");

  a_seq_bound: assert property (@(posedge clk) disable iff (rst)
    next_sequence <= SEQ_LIMIT)
    else $error("next_sequence beyond limit");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_CAP) |-> remaining != '0)
    else $error("chunk read with nothing left to send");

  a_cap_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CAP) |=> out_valid && chunk_bytes != 4'd0 &&
                          chunk_bytes <= 4'(CHUNK_BYTES))
    else $error("chunk register not loaded with a valid chunk");

  a_read_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CAP) |-> !out_valid)
    else $error("chunk loaded over an untaken one");

endmodule

// ===== tb/can_frame_reassembler_tb.sv =====
// Self-checking testbench for the CAN frame reassembler: directed and random frames, chunk checks.
module can_frame_reassembler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfr_pkg::*;

  localparam int unsigned STORE_BYTES = 256;
  localparam int unsigned IDLE_LIMIT  = 2000;

  typedef struct packed {
    logic [28:0]     id;
    logic [3:0]      dlc;
    logic [7:0][7:0] data;
  } can_frame_t;

  typedef struct packed {
    logic [3:0]      nbytes;
    logic [7:0][7:0] bytes;
    logic            last;
  } chunk_t;

  logic        clk;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [28:0] frame_id   = '0;
  logic [3:0]  byte_count = '0;
  logic [7:0]  data_0     = '0;
  logic [7:0]  data_1     = '0;
  logic [7:0]  data_2     = '0;
  logic [7:0]  data_3     = '0;
  logic [7:0]  data_4     = '0;
  logic [7:0]  data_5     = '0;
  logic [7:0]  data_6     = '0;
  logic [7:0]  data_7     = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [3:0]  chunk_bytes;
  logic [7:0]  out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7;
  logic        last_chunk;

  // shadow copy of the block's state
  logic [7:0]  shadow_store [STORE_BYTES];
  logic [7:0]  shadow_length  = '0;
  logic [7:0]  shadow_station = '0;
  logic [8:0]  shadow_seq     = '0;
  logic [8:0]  shadow_fill    = '0;
  logic        shadow_pending = 1'b0;

  chunk_t      due_chunks [$];
  int unsigned mismatches  = 0;
  int unsigned frames_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  bit          quiet       = 1'b0;

  can_frame_reassembler #(.STORE_BYTES(STORE_BYTES)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .frame_id(frame_id), .byte_count(byte_count),
    .data_0(data_0), .data_1(data_1), .data_2(data_2), .data_3(data_3),
    .data_4(data_4), .data_5(data_5), .data_6(data_6), .data_7(data_7),
    .out_valid(out_valid), .out_ready(out_ready),
    .chunk_bytes(chunk_bytes),
    .out_0(out_0), .out_1(out_1), .out_2(out_2), .out_3(out_3),
    .out_4(out_4), .out_5(out_5), .out_6(out_6), .out_7(out_7),
    .last_chunk(last_chunk)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned payload_len(input logic [3:0] dlc);
    return (dlc > CHUNK_BYTES) ? CHUNK_BYTES : int'(dlc);
  endfunction

  // Applies one accepted frame to the shadow state and queues the chunks it releases.
  function automatic void absorb_frame(input can_frame_t f);
    int unsigned n;
    int unsigned pos;
    int unsigned take;
    int unsigned k;
    chunk_t      c;
    n = payload_len(f.dlc);
    if (f.id == {21'd0, f.data[0]}) begin
      shadow_length  = (f.data[1] >= MIN_LENGTH) ? f.data[1] : 8'd0;
      shadow_station = f.data[0];
      shadow_seq     = '0;
      shadow_fill    = '0;
    end
    if (f.id[7:0] == shadow_station && {1'b0, f.id[15:8]} == shadow_seq) begin
      for (k = 0; k < n; k++) begin
        if (shadow_fill < STORE_BYTES) begin
          shadow_store[shadow_fill[7:0]] = f.data[k];
          shadow_fill++;
        end
      end
      if (shadow_seq < SEQ_LIMIT) shadow_seq++;
      shadow_pending = 1'b1;
    end
    if (shadow_fill == {1'b0, shadow_length} && shadow_pending) begin
      pos = 0;
      while (pos < shadow_fill) begin
        take = shadow_fill - pos;
        if (take > CHUNK_BYTES) take = CHUNK_BYTES;
        c = '0;
        c.nbytes = take[3:0];
        for (k = 0; k < take; k++) c.bytes[k] = shadow_store[8'(pos + k)];
        pos += take;
        c.last = (pos >= shadow_fill);
        due_chunks.push_back(c);
      end
      shadow_pending = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    mismatches++;
  endtask

  // One frame transaction; returns at the accepting edge.
  task automatic send_frame(input can_frame_t f);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    frame_id   <= f.id;
    byte_count <= f.dlc;
    data_0 <= f.data[0];
    data_1 <= f.data[1];
    data_2 <= f.data[2];
    data_3 <= f.data[3];
    data_4 <= f.data[4];
    data_5 <= f.data[5];
    data_6 <= f.data[6];
    data_7 <= f.data[7];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_frame(f);
    frames_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_chunks.size() != 0) @(posedge clk);
  endtask

  function automatic can_frame_t make_frame(input logic [28:0] id, input logic [3:0] dlc);
    can_frame_t f;
    int k;
    f.id  = id;
    f.dlc = dlc;
    for (k = 0; k < 8; k++) f.data[k] = 8'($urandom_range(0, 255));
    return f;
  endfunction

  function automatic can_frame_t start_frame(input logic [7:0] st, input logic [7:0] len,
                                             input logic [3:0] dlc);
    can_frame_t f;
    f = make_frame({21'd0, st}, dlc);
    f.data[0] = st;
    f.data[1] = len;
    return f;
  endfunction

  // continuation identifier with random don't-care upper bits
  function automatic logic [28:0] cont_id(input logic [7:0] seq, input logic [7:0] st);
    logic [12:0] hi;
    hi = 13'($urandom_range(0, 8191));
    return {hi, seq, st};
  endfunction

  task automatic test_reset_station();
    can_frame_t f;
    // after reset the station is 0 and the length 0: a bare match completes empty
    f = make_frame({13'h1FFF, 8'd0, 8'd0}, 4'd0);
    send_frame(f);
    f = start_frame(8'h00, 8'd5, 4'd5);
    send_frame(f);
  endtask

  task automatic test_basic_frames();
    can_frame_t f;
    f = start_frame(8'h3C, 8'd16, 4'd8);
    send_frame(f);
    f = make_frame(cont_id(8'd1, 8'h3C), 4'hF);
    f.data = '1;
    send_frame(f);
    f = start_frame(8'hC3, 8'd12, 4'd9);
    send_frame(f);
    f = make_frame(cont_id(8'd1, 8'hC3), 4'd4);
    f.data = '0;
    send_frame(f);
  endtask

  task automatic test_ignored_frames();
    can_frame_t f;
    f = start_frame(8'hA5, 8'd20, 4'd8);
    send_frame(f);
    send_frame(make_frame(cont_id(8'd1, 8'hA4), 4'd8));
    send_frame(make_frame(cont_id(8'd2, 8'hA5), 4'd8));
    send_frame(make_frame(29'h1FFF_FFFF, 4'd8));
    f = make_frame(29'h0A5, 4'd8);
    f.data[0] = 8'h00;
    send_frame(f);
    send_frame(make_frame(cont_id(8'd1, 8'hA5), 4'd8));
    send_frame(make_frame({13'h1FFF, 8'd2, 8'hA5}, 4'd4));
  endtask

  task automatic test_short_length();
    send_frame(start_frame(8'h10, 8'd4, 4'd0));
    send_frame(start_frame(8'h10, 8'd4, 4'd8));
    send_frame(make_frame(cont_id(8'd1, 8'h10), 4'd3));
    send_frame(start_frame(8'h11, 8'd5, 4'd5));
  endtask

  task automatic test_store_full();
    // carries on from the longest frame: the store saturates, later bytes are dropped
    send_frame(make_frame(cont_id(8'd32, 8'hFF), 4'd8));
    send_frame(make_frame(cont_id(8'd33, 8'hFF), 4'd8));
    send_frame(start_frame(8'h81, 8'd9, 4'd8));
    send_frame(make_frame(cont_id(8'd1, 8'h81), 4'd1));
  endtask

  task automatic test_longest_frame();
    can_frame_t f;
    int unsigned s;
    send_frame(start_frame(8'hFF, 8'd255, 4'd8));
    for (s = 1; s <= 30; s++) begin
      f = make_frame(cont_id(s[7:0], 8'hFF), 4'd8);
      if (s == 5) f.data = '1;
      if (s == 6) f.data = '0;
      send_frame(f);
    end
    send_frame(make_frame(cont_id(8'd31, 8'hFF), 4'd7));
    // hold the sender off until all 32 chunks are out
    wait_drained();
  endtask

  function automatic logic [3:0] pick_dlc(input int unsigned remaining, input bit broken);
    int unsigned n;
    if ($urandom_range(0, 5) == 0 || (broken && $urandom_range(0, 2) == 0))
      return 4'($urandom_range(0, 15));
    n = $urandom_range(1, 8);
    return (n > remaining) ? remaining[3:0] : n[3:0];
  endfunction

  // One message: a start frame and its continuations, with noise and, when broken,
  // frames that must be ignored. Stops early once the item budget is used.
  task automatic random_message(input int unsigned budget);
    logic [7:0]  st;
    logic [7:0]  seq;
    int unsigned target;
    int unsigned filled;
    int unsigned frames;
    int unsigned pick;
    bit          broken;
    can_frame_t  f;
    st     = 8'($urandom_range(0, 255));
    broken = ($urandom_range(0, 4) == 0);
    pick   = $urandom_range(0, 19);
    if (pick == 0)      target = $urandom_range(0, 4);
    else if (pick == 1) target = $urandom_range(41, 120);
    else                target = $urandom_range(5, 40);
    f = start_frame(st, target[7:0], pick_dlc(target, broken));
    send_frame(f);
    filled = payload_len(f.dlc);
    seq    = 8'd1;
    frames = 0;
    while (filled < target && frames < 40 && frames_sent < budget) begin
      if ($urandom_range(0, 7) == 0) begin
        send_frame(make_frame(29'($urandom_range(0, 29'h1FFF_FFFF)),
                              4'($urandom_range(0, 15))));
      end else if (broken && $urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 0)
          f = make_frame(cont_id(seq + 8'($urandom_range(1, 200)), st), 4'd8);
        else
          f = make_frame(cont_id(seq, st ^ 8'($urandom_range(1, 255))), 4'd8);
        send_frame(f);
      end else begin
        f = make_frame(cont_id(seq, st), pick_dlc(target - filled, broken));
        send_frame(f);
        filled += payload_len(f.dlc);
        seq++;
      end
      frames++;
    end
  endtask

  task automatic test_random();
    while (frames_sent < 90) random_message(90);
  endtask

  task automatic test_no_idling();
    quiet = 1'b1;
    while (frames_sent < 110) random_message(110);
  endtask

  // output side stalls in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_chunks
    chunk_t want;
    chunk_t got;
    int     k;
    if (!rst && out_valid && out_ready) begin
      got.nbytes = chunk_bytes;
      got.bytes  = {out_7, out_6, out_5, out_4, out_3, out_2, out_1, out_0};
      got.last   = last_chunk;
      if (due_chunks.size() == 0) begin
        report_mismatch("unexpected chunk, chunk_bytes", 0, got.nbytes);
      end else begin
        want = due_chunks.pop_front();
        if (got.nbytes !== want.nbytes) report_mismatch("chunk_bytes", want.nbytes, got.nbytes);
        for (k = 0; k < 8; k++)
          if (got.bytes[k] !== want.bytes[k])
            report_mismatch($sformatf("out_%0d", k), want.bytes[k], got.bytes[k]);
        if (got.last !== want.last) report_mismatch("last_chunk", want.last, got.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_station();
    test_basic_frames();
    test_ignored_frames();
    test_short_length();
    test_longest_frame();
    test_store_full();
    test_random();
    test_no_idling();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
